### rtl/core/wpt_pkg.sv
`default_nettype none

package wpt_pkg;

   localparam int FREQ_BITS      = 16;
   localparam int CONFIRM_BITS   = 4;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam int DIV_STEP_BITS  = $clog2(FREQ_BITS);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MEASURE_ENABLE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CONFIRM_COUNT  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FREQ_NUMERATOR = 2'd2;

   localparam logic                    RESET_MEASURE_ENABLE = 1'b1;
   localparam logic [CONFIRM_BITS-1:0] RESET_CONFIRM_COUNT  = 4'd5;
   localparam logic [FREQ_BITS-1:0]    RESET_FREQ_NUMERATOR = 16'd2000;

   localparam logic [DIV_STEP_BITS-1:0] DIV_LAST_STEP = DIV_STEP_BITS'(FREQ_BITS - 1);

   typedef struct packed {
      logic                 amp_updated;
      logic                 freq_updated;
      logic                 trend_rising;
      logic [FREQ_BITS-1:0] numerator;
      logic [FREQ_BITS-1:0] divisor;
   } job_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_DIV,
      BACK_DONE
   } back_state_type;

endpackage

`default_nettype wire

### rtl/core/wpt_queue.sv
`default_nettype none

module wpt_queue #(
   parameter int WIDTH = 44
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output logic [WIDTH-1:0]      pop_data
);

   localparam int DEPTH = 2;
   localparam int PTR_BITS = $clog2(DEPTH);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign push_ready = (count_ff != (PTR_BITS+1)'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### rtl/core/wpt_front.sv
`default_nettype none

module wpt_front #(
   parameter int SAMPLE_BITS = 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [SAMPLE_BITS-1:0]             req_sample,
   input  wire logic                               csr_write_en,
   input  wire logic [wpt_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [wpt_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output logic                                    push_valid,
   input  wire logic                               push_ready,
   output logic [SAMPLE_BITS-1:0]                  push_amplitude,
   output wpt_pkg::job_type                        push_job
);

   logic                                 enable_ff;
   logic [wpt_pkg::CONFIRM_BITS-1:0]     confirm_ff;
   logic [wpt_pkg::FREQ_BITS-1:0]        numer_ff;

   logic [SAMPLE_BITS-1:0]               prev_ff, prev_in;
   logic                                 trend_ff, trend_in;
   logic [wpt_pkg::CONFIRM_BITS-1:0]     cnt_ff, cnt_in;
   logic [SAMPLE_BITS-1:0]               trough_ff, trough_in;
   logic [SAMPLE_BITS-1:0]               peak_ff, peak_in;
   logic [wpt_pkg::FREQ_BITS-1:0]        period_ff, period_in;
   logic [SAMPLE_BITS-1:0]               amp_ff, amp_in;

   logic                                 accept;
   logic [wpt_pkg::FREQ_BITS-1:0]        period_inc;
   logic [wpt_pkg::CONFIRM_BITS-1:0]     cnt_next;
   logic [SAMPLE_BITS-1:0]               peak_new;
   logic                                 amp_upd, freq_upd;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && push_ready;

   always_comb begin
      prev_in    = prev_ff;
      trend_in   = trend_ff;
      cnt_in     = cnt_ff;
      trough_in  = trough_ff;
      peak_in    = peak_ff;
      period_in  = period_ff;
      amp_in     = amp_ff;
      amp_upd    = 1'b0;
      freq_upd   = 1'b0;
      period_inc = (period_ff != '1) ? period_ff + 1'b1 : period_ff;
      cnt_next   = cnt_ff + 1'b1;
      peak_new   = (cnt_ff == '0) ? req_sample : peak_ff;
      if (accept && enable_ff) begin
         period_in = period_inc;
         if (req_sample > prev_ff && !trend_ff) begin
            if (cnt_ff == '0) begin
               trough_in = req_sample;
            end
            cnt_in = cnt_next;
            if (cnt_next >= confirm_ff) begin
               trend_in  = 1'b1;
               cnt_in    = '0;
               period_in = '0;
               freq_upd  = 1'b1;
            end
         end else if (req_sample < prev_ff && trend_ff) begin
            peak_in = peak_new;
            cnt_in  = cnt_next;
            if (cnt_next >= confirm_ff) begin
               trend_in = 1'b0;
               cnt_in   = '0;
               amp_in   = (peak_new > trough_ff) ? peak_new - trough_ff : '0;
               amp_upd  = 1'b1;
            end
         end
         prev_in = req_sample;
      end
   end

   always_comb begin
      push_amplitude        = amp_in;
      push_job.amp_updated  = amp_upd;
      push_job.freq_updated = freq_upd;
      push_job.trend_rising = trend_in;
      push_job.numerator    = numer_ff;
      push_job.divisor      = period_inc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= wpt_pkg::RESET_MEASURE_ENABLE;
         confirm_ff <= wpt_pkg::RESET_CONFIRM_COUNT;
         numer_ff   <= wpt_pkg::RESET_FREQ_NUMERATOR;
      end else if (csr_write_en) begin
         case (csr_index)
            wpt_pkg::CSR_MEASURE_ENABLE: begin
               enable_ff <= csr_wdata[0];
            end
            wpt_pkg::CSR_CONFIRM_COUNT: begin
               confirm_ff <= csr_wdata[wpt_pkg::CONFIRM_BITS-1:0];
            end
            wpt_pkg::CSR_FREQ_NUMERATOR: begin
               numer_ff <= csr_wdata[wpt_pkg::FREQ_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff   <= '0;
         trend_ff  <= 1'b1;
         cnt_ff    <= '0;
         trough_ff <= '0;
         peak_ff   <= '0;
         period_ff <= '0;
         amp_ff    <= '0;
      end else begin
         prev_ff   <= prev_in;
         trend_ff  <= trend_in;
         cnt_ff    <= cnt_in;
         trough_ff <= trough_in;
         peak_ff   <= peak_in;
         period_ff <= period_in;
         amp_ff    <= amp_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/wpt_back.sv
`default_nettype none

module wpt_back #(
   parameter int SAMPLE_BITS = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          q_valid,
   output logic                               q_pop,
   input  wire logic [SAMPLE_BITS-1:0]        q_amplitude,
   input  wire wpt_pkg::job_type              q_job,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [SAMPLE_BITS-1:0]             rsp_amplitude,
   output logic [wpt_pkg::FREQ_BITS-1:0]      rsp_frequency,
   output logic                               rsp_amp_updated,
   output logic                               rsp_freq_updated,
   output logic                               rsp_trend_rising
);

   wpt_pkg::back_state_type state_ff, state_in;

   logic [SAMPLE_BITS-1:0]              amp_ff;
   wpt_pkg::job_type                    job_ff;
   logic [wpt_pkg::FREQ_BITS-1:0]       rem_ff;
   logic [wpt_pkg::FREQ_BITS-1:0]       quo_ff;
   logic [wpt_pkg::DIV_STEP_BITS-1:0]   step_ff;
   logic [wpt_pkg::FREQ_BITS-1:0]       freq_hold_ff;
   logic                                rsp_valid_ff;
   logic [SAMPLE_BITS-1:0]              rsp_amp_ff;
   logic [wpt_pkg::FREQ_BITS-1:0]       rsp_freq_ff;
   logic                                rsp_amp_upd_ff;
   logic                                rsp_freq_upd_ff;
   logic                                rsp_trend_ff;

   logic                                div_step, load;
   logic [wpt_pkg::FREQ_BITS:0]         trial;
   logic [wpt_pkg::FREQ_BITS-1:0]       freq_new;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wpt_pkg::BACK_IDLE: begin
            if (q_valid) begin
               state_in = q_job.freq_updated ? wpt_pkg::BACK_DIV : wpt_pkg::BACK_DONE;
            end
         end
         wpt_pkg::BACK_DIV: begin
            if (step_ff == wpt_pkg::DIV_LAST_STEP) begin
               state_in = wpt_pkg::BACK_DONE;
            end
         end
         wpt_pkg::BACK_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = wpt_pkg::BACK_IDLE;
            end
         end
         default: begin
            state_in = wpt_pkg::BACK_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      q_pop    = 1'b0;
      div_step = 1'b0;
      load     = 1'b0;
      case (state_ff)
         wpt_pkg::BACK_IDLE: begin
            q_pop = q_valid;
         end
         wpt_pkg::BACK_DIV: begin
            div_step = 1'b1;
         end
         wpt_pkg::BACK_DONE: begin
            load = !rsp_valid_ff || rsp_ready;
         end
         default: begin
         end
      endcase
   end

   // one restoring step per cycle
   assign trial    = {rem_ff, quo_ff[wpt_pkg::FREQ_BITS-1]} - {1'b0, job_ff.divisor};
   assign freq_new = job_ff.freq_updated ? quo_ff : freq_hold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wpt_pkg::BACK_IDLE;
         freq_hold_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load) begin
            freq_hold_ff <= freq_new;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         amp_ff  <= q_amplitude;
         job_ff  <= q_job;
         rem_ff  <= '0;
         quo_ff  <= q_job.numerator;
         step_ff <= '0;
      end else if (div_step) begin
         step_ff <= step_ff + 1'b1;
         if (!trial[wpt_pkg::FREQ_BITS]) begin
            rem_ff <= trial[wpt_pkg::FREQ_BITS-1:0];
            quo_ff <= {quo_ff[wpt_pkg::FREQ_BITS-2:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[wpt_pkg::FREQ_BITS-2:0], quo_ff[wpt_pkg::FREQ_BITS-1]};
            quo_ff <= {quo_ff[wpt_pkg::FREQ_BITS-2:0], 1'b0};
         end
      end
      if (load) begin
         rsp_amp_ff      <= amp_ff;
         rsp_freq_ff     <= freq_new;
         rsp_amp_upd_ff  <= job_ff.amp_updated;
         rsp_freq_upd_ff <= job_ff.freq_updated;
         rsp_trend_ff    <= job_ff.trend_rising;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_amplitude    = rsp_amp_ff;
   assign rsp_frequency    = rsp_freq_ff;
   assign rsp_amp_updated  = rsp_amp_upd_ff;
   assign rsp_freq_updated = rsp_freq_upd_ff;
   assign rsp_trend_rising = rsp_trend_ff;

endmodule

`default_nettype wire

### rtl/core/waveform_peak_trough_measure.sv
// Waveform peak / trough measurement.
// Input channel req_*: one ADC sample per transaction. Result channel rsp_*:
// exactly one transaction per accepted sample, in order, carrying the held
// amplitude and frequency, the two updated flags and the trend after it.
// Configuration csr_*: one register written per cycle with csr_write_en high;
// index 0 measure_enable, 1 confirm_count, 2 freq_numerator. Write only idle.
// The front stage takes a sample and updates trend, peak, trough and
// amplitude at once; a two-entry queue passes each transaction to the
// back stage, which owns the frequency divider and the output register.
// A result passes the queue, the back stage's job register and the output
// register; a sample that confirms a falling-to-rising turn also passes the
// 16-step restoring divider, which makes one quotient bit per cycle. The back
// stage pops no new transaction until the last one is in the output register.
// Reset clears front-stage state, restores the register defaults and empties the
// queue and output register. While rsp_ready is low the result holds, the
// queue fills and req_ready drops once both entries are taken.
`default_nettype none

module waveform_peak_trough_measure #(
   parameter int SAMPLE_BITS = 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [SAMPLE_BITS-1:0]             req_sample,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [SAMPLE_BITS-1:0]                  rsp_amplitude,
   output logic [wpt_pkg::FREQ_BITS-1:0]           rsp_frequency,
   output logic                                    rsp_amp_updated,
   output logic                                    rsp_freq_updated,
   output logic                                    rsp_trend_rising,
   input  wire logic                               csr_write_en,
   input  wire logic [wpt_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [wpt_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int JOB_BITS = $bits(wpt_pkg::job_type);
   localparam int Q_BITS   = JOB_BITS + SAMPLE_BITS;

   logic                   push_valid, push_ready;
   logic [SAMPLE_BITS-1:0] push_amplitude;
   wpt_pkg::job_type       push_job;
   logic                   pop_valid, pop_ready;
   logic [Q_BITS-1:0]      push_data, pop_data;
   logic [SAMPLE_BITS-1:0] pop_amplitude;
   wpt_pkg::job_type       pop_job;

   assign push_data     = {push_amplitude, push_job};
   assign pop_amplitude = pop_data[Q_BITS-1:JOB_BITS];
   assign pop_job       = pop_data[JOB_BITS-1:0];

   wpt_front #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample     (req_sample),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_amplitude (push_amplitude),
      .push_job       (push_job)
   );

   wpt_queue #(
      .WIDTH(Q_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   wpt_back #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (pop_valid),
      .q_pop            (pop_ready),
      .q_amplitude      (pop_amplitude),
      .q_job            (pop_job),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_amplitude    (rsp_amplitude),
      .rsp_frequency    (rsp_frequency),
      .rsp_amp_updated  (rsp_amp_updated),
      .rsp_freq_updated (rsp_freq_updated),
      .rsp_trend_rising (rsp_trend_rising)
   );

endmodule

`default_nettype wire

### rtl/core/wpt_checker.sv
`default_nettype none

module wpt_checker #(
   parameter int SAMPLE_BITS = 8
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [SAMPLE_BITS-1:0]        rsp_amplitude,
   input wire logic [wpt_pkg::FREQ_BITS-1:0] rsp_frequency,
   input wire logic                          rsp_amp_updated,
   input wire logic                          rsp_freq_updated,
   input wire logic                          rsp_trend_rising
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_amplitude)
         && $stable(rsp_frequency) && $stable(rsp_trend_rising))
      else $error("stalled rsp transaction changed");

   a_one_update: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_amp_updated && rsp_freq_updated))
      else $error("amplitude and frequency updated by one sample");

   a_amp_falls: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_amp_updated |-> !rsp_trend_rising)
      else $error("amplitude update without falling trend");

   a_freq_rises: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_freq_updated |-> rsp_trend_rising)
      else $error("frequency update without rising trend");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

endmodule

bind waveform_peak_trough_measure wpt_checker #(
   .SAMPLE_BITS(SAMPLE_BITS)
) u_wpt_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_amplitude    (rsp_amplitude),
   .rsp_frequency    (rsp_frequency),
   .rsp_amp_updated  (rsp_amp_updated),
   .rsp_freq_updated (rsp_freq_updated),
   .rsp_trend_rising (rsp_trend_rising)
);

`default_nettype wire

### sim/wpt_measure_check.sv
`timescale 1ns / 100ps

module wpt_measure_check #(
   parameter int SAMPLE_BITS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic [SAMPLE_BITS-1:0]             req_sample,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic [SAMPLE_BITS-1:0]             rsp_amplitude,
   input  logic [wpt_pkg::FREQ_BITS-1:0]      rsp_frequency,
   input  logic                               rsp_amp_updated,
   input  logic                               rsp_freq_updated,
   input  logic                               rsp_trend_rising,
   input  logic                               csr_write_en,
   input  logic [wpt_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [wpt_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output int                                 fail_count,
   output int                                 outstanding,
   output int                                 checked_count,
   output int                                 turn_count
);

   typedef struct packed {
      logic [SAMPLE_BITS-1:0]        amplitude;
      logic [wpt_pkg::FREQ_BITS-1:0] frequency;
      logic                          amp_updated;
      logic                          freq_updated;
      logic                          trend_rising;
   } measurement_type;

   measurement_type expected_q[$];
   measurement_type predicted;
   measurement_type want;

   logic                             cfg_enable;
   logic [wpt_pkg::CONFIRM_BITS-1:0] cfg_confirm;
   logic [wpt_pkg::FREQ_BITS-1:0]    cfg_numerator;

   logic [SAMPLE_BITS-1:0]           last_sample;
   logic                             rising;
   logic [wpt_pkg::CONFIRM_BITS-1:0] against_run;
   logic [SAMPLE_BITS-1:0]           trough;
   logic [SAMPLE_BITS-1:0]           peak;
   logic [wpt_pkg::FREQ_BITS-1:0]    since_turn;
   logic [SAMPLE_BITS-1:0]           amp_held;
   logic [wpt_pkg::FREQ_BITS-1:0]    freq_held;
   logic                             amp_now;
   logic                             freq_now;

   int errors = 0;
   int results = 0;
   int turns = 0;

   task automatic report_mismatch(input string msg);
      errors++;
      $display("mismatch at result %0d: %s", results, msg);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_enable    = wpt_pkg::RESET_MEASURE_ENABLE;
         cfg_confirm   = wpt_pkg::RESET_CONFIRM_COUNT;
         cfg_numerator = wpt_pkg::RESET_FREQ_NUMERATOR;
         last_sample   = '0;
         rising        = 1'b1;
         against_run   = '0;
         trough        = '0;
         peak          = '0;
         since_turn    = '0;
         amp_held      = '0;
         freq_held     = '0;
         expected_q.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               wpt_pkg::CSR_MEASURE_ENABLE: cfg_enable = csr_wdata[0];
               wpt_pkg::CSR_CONFIRM_COUNT:
                  cfg_confirm = csr_wdata[wpt_pkg::CONFIRM_BITS-1:0];
               wpt_pkg::CSR_FREQ_NUMERATOR:
                  cfg_numerator = csr_wdata[wpt_pkg::FREQ_BITS-1:0];
               default: ;
            endcase
         end

         if (req_valid && req_ready) begin
            amp_now  = 1'b0;
            freq_now = 1'b0;
            if (cfg_enable) begin
               if (since_turn != '1) since_turn = since_turn + 1'b1;
               if (req_sample > last_sample && !rising) begin
                  if (against_run == '0) trough = req_sample;
                  against_run = against_run + 1'b1;
                  if (against_run >= cfg_confirm) begin
                     rising      = 1'b1;
                     against_run = '0;
                     freq_held   = cfg_numerator / since_turn;
                     since_turn  = '0;
                     freq_now    = 1'b1;
                  end
               end else if (req_sample < last_sample && rising) begin
                  if (against_run == '0) peak = req_sample;
                  against_run = against_run + 1'b1;
                  if (against_run >= cfg_confirm) begin
                     rising      = 1'b0;
                     against_run = '0;
                     amp_held    = (peak > trough) ? peak - trough : '0;
                     amp_now     = 1'b1;
                  end
               end
               last_sample = req_sample;
            end
            predicted = '{amp_held, freq_held, amp_now, freq_now, rising};
            expected_q.push_back(predicted);
         end

         if (rsp_valid && rsp_ready) begin
            results++;
            if (expected_q.size() == 0) begin
               report_mismatch("result with no sample waiting for it");
            end else begin
               want = expected_q.pop_front();
               if (want.amp_updated || want.freq_updated) turns++;
               if (rsp_amplitude !== want.amplitude)
                  report_mismatch($sformatf("amplitude %0d, expected %0d",
                                            rsp_amplitude, want.amplitude));
               if (rsp_frequency !== want.frequency)
                  report_mismatch($sformatf("frequency %0d, expected %0d",
                                            rsp_frequency, want.frequency));
               if (rsp_amp_updated !== want.amp_updated)
                  report_mismatch($sformatf("amp_updated %b, expected %b",
                                            rsp_amp_updated, want.amp_updated));
               if (rsp_freq_updated !== want.freq_updated)
                  report_mismatch($sformatf("freq_updated %b, expected %b",
                                            rsp_freq_updated, want.freq_updated));
               if (rsp_trend_rising !== want.trend_rising)
                  report_mismatch($sformatf("trend_rising %b, expected %b",
                                            rsp_trend_rising, want.trend_rising));
            end
         end
      end
      fail_count    <= errors;
      outstanding   <= expected_q.size();
      checked_count <= results;
      turn_count    <= turns;
   end

endmodule

### sim/tb.sv
`timescale 1ns / 100ps

module tb;

   localparam int SAMPLE_BITS = 8;
   localparam int MAX_CYCLES = 5_000_000;
   localparam int FLAT_RUN = 100;
   localparam int PHASE_ITEMS = 500;
   localparam int SETTLE_CYCLES = 24;
   localparam logic [wpt_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE = 2'd3;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   logic [SAMPLE_BITS-1:0]             req_sample = '0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic [SAMPLE_BITS-1:0]             rsp_amplitude;
   logic [wpt_pkg::FREQ_BITS-1:0]      rsp_frequency;
   logic                               rsp_amp_updated;
   logic                               rsp_freq_updated;
   logic                               rsp_trend_rising;
   logic                               csr_write_en = 1'b0;
   logic [wpt_pkg::CSR_INDEX_BITS-1:0] csr_index = wpt_pkg::CSR_MEASURE_ENABLE;
   logic [wpt_pkg::CSR_DATA_BITS-1:0]  csr_wdata = '0;

   int fail_count;
   int outstanding;
   int checked_count;
   int turn_count;

   int send_idle_pct = 0;
   int take_idle_pct = 0;
   int cycles = 0;
   int samples_sent = 0;
   int settings_used = 0;

   logic [SAMPLE_BITS-1:0] turn_walk [9] = '{8'd255, 8'd0, 8'd85, 8'd170, 8'd170,
                                             8'd0, 8'd1, 8'd255, 8'd254};
   logic [SAMPLE_BITS-1:0] slow_confirm [7] = '{8'd100, 8'd120, 8'd120, 8'd110,
                                                8'd130, 8'd90, 8'd140};

   waveform_peak_trough_measure #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_amplitude   (rsp_amplitude),
      .rsp_frequency   (rsp_frequency),
      .rsp_amp_updated (rsp_amp_updated),
      .rsp_freq_updated(rsp_freq_updated),
      .rsp_trend_rising(rsp_trend_rising),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   wpt_measure_check #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) measure_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_amplitude   (rsp_amplitude),
      .rsp_frequency   (rsp_frequency),
      .rsp_amp_updated (rsp_amp_updated),
      .rsp_freq_updated(rsp_freq_updated),
      .rsp_trend_rising(rsp_trend_rising),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .outstanding     (outstanding),
      .checked_count   (checked_count),
      .turn_count      (turn_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= take_idle_pct);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > MAX_CYCLES) begin
         $display("timeout after %0d cycles, %0d results still expected", cycles, outstanding);
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic send_sample(input logic [SAMPLE_BITS-1:0] value);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      samples_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [wpt_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [wpt_pkg::CSR_DATA_BITS-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic enable,
                                 input logic [wpt_pkg::CONFIRM_BITS-1:0] confirm,
                                 input logic [wpt_pkg::FREQ_BITS-1:0] numerator);
      wait_idle();
      write_reg(wpt_pkg::CSR_MEASURE_ENABLE, wpt_pkg::CSR_DATA_BITS'(enable));
      write_reg(wpt_pkg::CSR_CONFIRM_COUNT, wpt_pkg::CSR_DATA_BITS'(confirm));
      write_reg(wpt_pkg::CSR_FREQ_NUMERATOR, wpt_pkg::CSR_DATA_BITS'(numerator));
      // unmapped index, must not disturb anything
      write_reg(CSR_SPARE, wpt_pkg::CSR_DATA_BITS'($urandom));
      csr_write_en <= 1'b0;
      settings_used++;
   endtask

   task automatic run_wave(input int count);
      int level;
      int target;
      int max_step;
      int step;
      int value;
      level    = $urandom_range(255);
      target   = $urandom_range(255);
      max_step = $urandom_range(1, 48);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(7) != 0) begin
            step = $urandom_range(1, max_step);
            if (target > level) level = (level + step > target) ? target : level + step;
            else if (target < level) level = (level - step < target) ? target : level - step;
         end
         if (level == target) begin
            if ($urandom_range(3) == 0) target = $urandom_range(1) ? 255 : 0;
            else target = $urandom_range(255);
         end
         value = level;
         if ($urandom_range(5) == 0) value = value + int'($urandom_range(4)) - 2;
         if (value < 0) value = 0;
         else if (value > 255) value = 255;
         send_sample(SAMPLE_BITS'(value));
      end
   endtask

   task automatic run_phase(input int sender_pct, input int receiver_pct, input int items);
      int phase_sent;
      int len;
      logic enable;
      logic [wpt_pkg::CONFIRM_BITS-1:0] confirm;
      logic [wpt_pkg::FREQ_BITS-1:0] numerator;
      phase_sent = 0;
      send_idle_pct = sender_pct;
      take_idle_pct = receiver_pct;
      while (phase_sent < items) begin
         enable = ($urandom_range(7) != 0);
         case ($urandom_range(5))
            0: confirm = 4'd1;
            1: confirm = 4'd15;
            2: confirm = 4'd0;
            default: confirm = wpt_pkg::CONFIRM_BITS'($urandom_range(1, 6));
         endcase
         case ($urandom_range(3))
            0: numerator = 16'd1;
            1: numerator = 16'hFFFF;
            default: numerator = wpt_pkg::FREQ_BITS'($urandom);
         endcase
         apply_settings(enable, confirm, numerator);
         len = $urandom_range(20, 120);
         if ($urandom_range(4) == 0) begin
            for (int i = 0; i < len; i++) send_sample(SAMPLE_BITS'($urandom));
         end else begin
            run_wave(len);
         end
         phase_sent += len;
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero confirm count, equal samples, clamped and largest amplitude
      apply_settings(1'b1, 4'd0, 16'hFFFF);
      foreach (turn_walk[i]) send_sample(turn_walk[i]);

      // ignored samples while disabled
      apply_settings(1'b0, 4'd3, 16'd1);
      send_sample(8'd200);
      send_sample(8'd7);

      // samples off the trend must not reset the confirmation run
      apply_settings(1'b1, 4'd3, 16'd1);
      foreach (slow_confirm[i]) send_sample(slow_confirm[i]);

      // long flat stretch between turns
      apply_settings(1'b1, 4'd1, 16'hFFFF);
      send_sample(8'd200);
      send_sample(8'd128);
      repeat (FLAT_RUN) send_sample(8'd128);
      send_sample(8'd129);

      run_phase(23, 51, PHASE_ITEMS);
      run_phase(51, 23, PHASE_ITEMS);
      run_phase(0, 0, PHASE_ITEMS);

      wait_idle();
      $display("%0d samples driven under %0d register settings, including a %0d-sample flat run",
               samples_sent, settings_used, FLAT_RUN);
      $display("%0d results checked, %0d of them reporting a confirmed turn",
               checked_count, turn_count);
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/core/wpt_pkg.sv
rtl/core/wpt_queue.sv
rtl/core/wpt_front.sv
rtl/core/wpt_back.sv
rtl/core/waveform_peak_trough_measure.sv
rtl/core/wpt_checker.sv
sim/wpt_measure_check.sv
sim/tb.sv
